[hdl/i2c_master_pin_sequencer_assert.svh]
// assertion macros shared by the i2c pin sequencer modules
`ifndef I2C_MASTER_PIN_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_PIN_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define IMPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("i2c pin sequencer check failed");
// antecedent at one edge implies consequent at the next
`define IMPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c pin sequencer check failed");
`else
`define IMPS_ASSERT(lbl, prop)
`define IMPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/imps_pkg.sv]
// shared types, codes and phase tables of the i2c pin sequencer
package imps_pkg;

	localparam int unsigned PHASE_W = 5;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_STOP      = 3'd1,
		CMD_WRITE     = 3'd2,
		CMD_READ      = 3'd3,
		CMD_SEND_ACK  = 3'd4,
		CMD_RECV_ACK  = 3'd5
	} cmd_t;

	// one queued command, already classified by the front
	typedef struct packed {
		cmd_t               cmd;
		logic [7:0]         tx_byte;
		logic               ack_level;
		logic [7:0]         bus_sda_bits;
		logic [PHASE_W-1:0] last_idx;
	} entry_t;

	// index of the final pin phase of each command
	function automatic logic [PHASE_W-1:0] last_idx_of(cmd_t c);
		logic [PHASE_W-1:0] r;
		unique case (c)
			CMD_START:    r = PHASE_W'(3);
			CMD_STOP:     r = PHASE_W'(2);
			CMD_WRITE:    r = PHASE_W'(23);
			CMD_READ:     r = PHASE_W'(16);
			CMD_SEND_ACK: r = PHASE_W'(2);
			CMD_RECV_ACK: r = PHASE_W'(2);
			default:      r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/imps_if.sv]
// valid/ready channels for commands and pin phase beats
interface imps_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] tx_byte;
	logic       ack_level;
	logic [7:0] bus_sda_bits;

	modport source (output valid, output op, output tx_byte, output ack_level,
		output bus_sda_bits, input ready);
	modport sink (input valid, input op, input tx_byte, input ack_level,
		input bus_sda_bits, output ready);
endinterface

interface imps_phase_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic [7:0] read_byte;
	logic       ack_seen;
	logic       last;

	modport source (output valid, output scl_level, output sda_level,
		output read_byte, output ack_seen, output last, input ready);
	modport sink (input valid, input scl_level, input sda_level,
		input read_byte, input ack_seen, input last, output ready);
endinterface

[hdl/imps_front.sv]
// command front: accepts beats, drops unused opcodes, queues classified commands
`include "i2c_master_pin_sequencer_assert.svh"
module imps_front #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	imps_cmd_if.sink            cmd,
	output logic                q_valid,
	output imps_pkg::entry_t    q_entry,
	input  logic                q_pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	imps_pkg::entry_t   slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               op_ok;
	logic               push;
	imps_pkg::entry_t   new_entry;

	// classify the incoming command
	always_comb begin
		op_ok = (cmd.op == imps_pkg::CMD_START) || (cmd.op == imps_pkg::CMD_STOP)
			|| (cmd.op == imps_pkg::CMD_WRITE) || (cmd.op == imps_pkg::CMD_READ)
			|| (cmd.op == imps_pkg::CMD_SEND_ACK) || (cmd.op == imps_pkg::CMD_RECV_ACK);
		new_entry.cmd          = imps_pkg::cmd_t'(cmd.op);
		new_entry.tx_byte      = cmd.tx_byte;
		new_entry.ack_level    = cmd.ack_level;
		new_entry.bus_sda_bits = cmd.bus_sda_bits;
		new_entry.last_idx     = imps_pkg::last_idx_of(imps_pkg::cmd_t'(cmd.op));
	end

	assign cmd.ready = (count_q != CNT_W'(DEPTH));
	assign push      = cmd.valid && cmd.ready && op_ok;
	assign q_valid   = (count_q != '0);
	assign q_entry   = slots_q[rd_ptr_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= new_entry;
		end
	end

	`IMPS_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH))
	`IMPS_ASSERT(a_no_pop_empty, !q_pop || q_valid)
	`IMPS_ASSERT_NEXT(a_push_grows, push && !q_pop, count_q == $past(count_q) + 1'b1)

endmodule

[hdl/imps_back.sv]
// pin back end: steps through the phases of one command, one beat per phase
`include "i2c_master_pin_sequencer_assert.svh"
module imps_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  imps_pkg::entry_t    q_entry,
	output logic                q_pop,
	imps_phase_if.source        phase
);

	logic                        busy_q;
	imps_pkg::entry_t            ent_q;
	logic [imps_pkg::PHASE_W-1:0] cnt_q;
	logic [1:0]                  sub_q;
	logic [7:0]                  tx_q;
	logic                        scl_q;
	logic                        sda_q;
	logic                        ov_q;
	logic                        o_scl_q;
	logic                        o_sda_q;
	logic [7:0]                  o_rb_q;
	logic                        o_ack_q;
	logic                        o_last_q;
	logic                        adv;
	logic                        is_last;
	logic                        scl_nx;
	logic                        sda_nx;
	logic [7:0]                  rb_nx;
	logic                        ack_nx;

	assign adv     = busy_q && (!ov_q || phase.ready);
	assign q_pop   = !busy_q && q_valid;
	assign is_last = (cnt_q == ent_q.last_idx);

	// pin levels after the current phase
	always_comb begin
		scl_nx = scl_q;
		sda_nx = sda_q;
		unique case (ent_q.cmd)
			imps_pkg::CMD_START: begin
				unique case (cnt_q[1:0])
					2'd0: sda_nx = 1'b1;
					2'd1: scl_nx = 1'b1;
					2'd2: sda_nx = 1'b0;
					2'd3: scl_nx = 1'b0;
				endcase
			end
			imps_pkg::CMD_STOP: begin
				priority case (cnt_q[1:0])
					2'd0:    sda_nx = 1'b0;
					2'd1:    scl_nx = 1'b1;
					default: sda_nx = 1'b1;
				endcase
			end
			imps_pkg::CMD_READ: begin
				if (cnt_q == '0) begin
					sda_nx = 1'b1;
				end else begin
					scl_nx = cnt_q[0];
				end
			end
			imps_pkg::CMD_WRITE, imps_pkg::CMD_SEND_ACK, imps_pkg::CMD_RECV_ACK: begin
				priority case (sub_q)
					2'd0: begin
						if (ent_q.cmd == imps_pkg::CMD_WRITE) begin
							sda_nx = tx_q[7];
						end else if (ent_q.cmd == imps_pkg::CMD_SEND_ACK) begin
							sda_nx = ent_q.ack_level;
						end else begin
							sda_nx = 1'b1;
						end
					end
					2'd1:    scl_nx = 1'b1;
					default: scl_nx = 1'b0;
				endcase
			end
			default: begin
				scl_nx = scl_q;
				sda_nx = sda_q;
			end
		endcase
	end

	// sampled data shown on the final phase only
	always_comb begin
		rb_nx  = (is_last && ent_q.cmd == imps_pkg::CMD_READ) ? ent_q.bus_sda_bits : 8'h00;
		ack_nx = is_last && (ent_q.cmd == imps_pkg::CMD_RECV_ACK) && ent_q.bus_sda_bits[7];
	end

	// sequencer control and pin state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (adv && is_last) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				ov_q  <= 1'b1;
				scl_q <= scl_nx;
				sda_q <= sda_nx;
			end else if (phase.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// command registers and phase counters
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_entry;
			tx_q  <= q_entry.tx_byte;
			cnt_q <= '0;
			sub_q <= '0;
		end else if (adv) begin
			cnt_q <= cnt_q + 1'b1;
			sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 1'b1;
			if (sub_q == 2'd2) begin
				tx_q <= {tx_q[6:0], 1'b0};
			end
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (adv) begin
			o_scl_q  <= scl_nx;
			o_sda_q  <= sda_nx;
			o_rb_q   <= rb_nx;
			o_ack_q  <= ack_nx;
			o_last_q <= is_last;
		end
	end

	assign phase.valid     = ov_q;
	assign phase.scl_level = o_scl_q;
	assign phase.sda_level = o_sda_q;
	assign phase.read_byte = o_rb_q;
	assign phase.ack_seen  = o_ack_q;
	assign phase.last      = o_last_q;

	`IMPS_ASSERT(a_cnt_bound, !busy_q || cnt_q <= ent_q.last_idx)
	`IMPS_ASSERT(a_sub_bound, !busy_q || sub_q != 2'd3)
	`IMPS_ASSERT_NEXT(a_last_ends, adv && is_last, !busy_q && ov_q && o_last_q)

endmodule

[hdl/i2c_master_pin_sequencer.sv]
// i2c master pin sequencer top: command front, queue and pin back end
// first beat path: queue slot, command registers, then the output beat register
// throughput: one phase beat per cycle while phase.ready holds, plus a load step
//   per command, when the back end takes the next command off the queue
// unused opcodes are accepted and dropped without a beat
// reset: both pins released (level 1), queue empty, no beat pending
module i2c_master_pin_sequencer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	imps_cmd_if.sink      cmd,
	imps_phase_if.source  phase
);

	logic             q_valid;
	logic             q_pop;
	imps_pkg::entry_t q_entry;

	// accept and classify
	imps_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	// drive pin phases
	imps_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.phase   (phase)
	);

endmodule
